// File: rtl/sawtc_pkg.sv
package sawtc_pkg;

  localparam int unsigned TAG_W  = 19;
  localparam int unsigned SET_W  = 7;
  localparam int unsigned NSETS  = 128;
  localparam int unsigned LWORDS = 16;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_FILL  = 2'd2;

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_FILL,
    KIND_WRITE,
    KIND_ERROR
  } kind_e;

  typedef enum logic [1:0] {
    DSEL_FILL,
    DSEL_W0,
    DSEL_W1
  } dsel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TAG,
    ST_CMP,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_WR0,
    ST_WR1,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic  capture;
    logic  start_access;
    logic  set_part2;
    logic  charge;
    logic  latch_way;
    logic  set_hit;
    logic  data_we;
    dsel_e dsel;
    logic  beat_inc;
    logic  fill_start;
    logic  fill_done;
    logic  cap_w0;
    logic  assemble;
    logic  out_load;
    kind_e out_kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       size_ok;
    logic       fill_active;
    logic       beat_last;
    logic       hit;
    logic       span;
    logic       part2;
    logic       out_free;
  } stat_t;

endpackage

// File: rtl/sawtc_ram.sv
module sawtc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [WIDTH-1:0]         wmask_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= (mem_q[addr_i] & ~wmask_i) | (wdata_i & wmask_i);
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sawtc_ctrl.sv
module sawtc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sawtc_pkg::stat_t stat_i,
  output sawtc_pkg::cmd_t  cmd_o
);

  sawtc_pkg::state_e state_q, state_d;
  sawtc_pkg::kind_e  kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sawtc_pkg::ST_IDLE;
      kind_q  <= sawtc_pkg::KIND_READ;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    kind_d     = kind_q;
    in_ready_o = 1'b0;
    case (state_q)
      sawtc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sawtc_pkg::ST_DECODE;
        end
      end
      sawtc_pkg::ST_DECODE: begin
        if (stat_i.func == sawtc_pkg::FUNC_FILL) begin
          if (!stat_i.fill_active) begin
            kind_d  = sawtc_pkg::KIND_ERROR;
            state_d = sawtc_pkg::ST_EMIT;
          end else begin
            cmd_o.data_we = 1'b1;
            cmd_o.dsel    = sawtc_pkg::DSEL_FILL;
            if (stat_i.beat_last) begin
              cmd_o.fill_done = 1'b1;
              state_d         = sawtc_pkg::ST_RD0;
            end else begin
              cmd_o.beat_inc = 1'b1;
              state_d        = sawtc_pkg::ST_IDLE;
            end
          end
        end else if ((stat_i.func == sawtc_pkg::FUNC_READ ||
                      stat_i.func == sawtc_pkg::FUNC_WRITE) &&
                     !stat_i.fill_active && stat_i.size_ok) begin
          cmd_o.start_access = 1'b1;
          state_d            = sawtc_pkg::ST_TAG;
        end else begin
          kind_d  = sawtc_pkg::KIND_ERROR;
          state_d = sawtc_pkg::ST_EMIT;
        end
      end
      sawtc_pkg::ST_TAG: begin
        state_d = sawtc_pkg::ST_CMP;
      end
      sawtc_pkg::ST_CMP: begin
        cmd_o.latch_way = 1'b1;
        if (stat_i.func == sawtc_pkg::FUNC_WRITE) begin
          if (stat_i.hit) begin
            cmd_o.set_hit = 1'b1;
            state_d       = sawtc_pkg::ST_WR0;
          end else if (!stat_i.part2 && stat_i.span) begin
            cmd_o.set_part2 = 1'b1;
            state_d         = sawtc_pkg::ST_TAG;
          end else begin
            kind_d  = sawtc_pkg::KIND_WRITE;
            state_d = sawtc_pkg::ST_EMIT;
          end
        end else begin
          cmd_o.charge = 1'b1;
          if (stat_i.hit) begin
            cmd_o.set_hit = 1'b1;
            state_d       = sawtc_pkg::ST_RD0;
          end else begin
            cmd_o.fill_start = 1'b1;
            kind_d           = sawtc_pkg::KIND_FILL;
            state_d          = sawtc_pkg::ST_EMIT;
          end
        end
      end
      sawtc_pkg::ST_RD0: begin
        cmd_o.dsel = sawtc_pkg::DSEL_W0;
        state_d    = sawtc_pkg::ST_RD1;
      end
      sawtc_pkg::ST_RD1: begin
        cmd_o.dsel   = sawtc_pkg::DSEL_W1;
        cmd_o.cap_w0 = 1'b1;
        state_d      = sawtc_pkg::ST_RD2;
      end
      sawtc_pkg::ST_RD2: begin
        cmd_o.assemble = 1'b1;
        if (!stat_i.part2 && stat_i.span) begin
          cmd_o.set_part2 = 1'b1;
          state_d         = sawtc_pkg::ST_TAG;
        end else begin
          kind_d  = sawtc_pkg::KIND_READ;
          state_d = sawtc_pkg::ST_EMIT;
        end
      end
      sawtc_pkg::ST_WR0: begin
        cmd_o.data_we = 1'b1;
        cmd_o.dsel    = sawtc_pkg::DSEL_W0;
        state_d       = sawtc_pkg::ST_WR1;
      end
      sawtc_pkg::ST_WR1: begin
        cmd_o.data_we = 1'b1;
        cmd_o.dsel    = sawtc_pkg::DSEL_W1;
        if (!stat_i.part2 && stat_i.span) begin
          cmd_o.set_part2 = 1'b1;
          state_d         = sawtc_pkg::ST_TAG;
        end else begin
          kind_d  = sawtc_pkg::KIND_WRITE;
          state_d = sawtc_pkg::ST_EMIT;
        end
      end
      sawtc_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = kind_q;
          state_d        = sawtc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sawtc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/sawtc_dp.sv
module sawtc_dp #(
  parameter int unsigned WAYS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sawtc_pkg::cmd_t  cmd_i,
  output sawtc_pkg::stat_t stat_o,
  input  logic [1:0]       in_func_i,
  input  logic [31:0]      in_addr_i,
  input  logic [2:0]       in_size_i,
  input  logic [31:0]      in_wdata_i,
  input  logic [2:0]       in_vf_i,
  input  logic [2:0]       in_vs_i,
  input  logic [31:0]      in_fword_i,
  input  logic [15:0]      hit_cost_i,
  input  logic [15:0]      mem_cost_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       out_kind_o,
  output logic [31:0]      out_rdata_o,
  output logic             out_hit_first_o,
  output logic             out_hit_second_o,
  output logic [31:0]      out_mem_addr_o,
  output logic [2:0]       out_mem_len_o,
  output logic [31:0]      out_mem_data_o,
  output logic [63:0]      out_cached_o,
  output logic [63:0]      out_uncached_o
);

  localparam int unsigned WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned LIW    = $clog2(sawtc_pkg::NSETS * WAYS);
  localparam int unsigned DAW    = LIW + 4;
  localparam int unsigned DDEPTH = sawtc_pkg::NSETS * WAYS * sawtc_pkg::LWORDS;

  function automatic logic [31:0] byte_mask(input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  logic [1:0]  in_func_q;
  logic [31:0] in_addr_q, in_wdata_q, in_fword_q;
  logic [2:0]  in_size_q, in_vf_q, in_vs_q;

  logic [31:0] ha_q;
  logic [2:0]  hs_q, vf_q, vs_q;
  logic        part2_q, h1_q, h2_q, fill_active_q;
  logic [WW-1:0] way_q;
  logic [3:0]  beat_q;
  logic [31:0] assembled_q, w0_q;
  logic [63:0] cached_q, uncached_q;
  logic [WAYS-1:0] valid_q [sawtc_pkg::NSETS];

  logic        out_valid_q, out_h1_q, out_h2_q;
  logic [1:0]  out_kind_q;
  logic [31:0] out_rdata_q, out_maddr_q, out_mdata_q;
  logic [2:0]  out_mlen_q;
  logic [63:0] out_cached_q, out_uncached_q;

  logic [31:0] a2, la;
  logic [sawtc_pkg::SET_W-1:0] set_s;
  logic [sawtc_pkg::TAG_W-1:0] tag_s;
  logic        span;
  logic [5:0]  off;
  logic [6:0]  len1_w;
  logic [2:0]  len1, at, cnt;
  logic [31:0] cmask, ext, dsh;
  logic [63:0] buf64, d64, m64;
  logic [4:0]  sh_at, sh_off;
  logic        out_free;

  assign a2     = ha_q + 32'(hs_q) - 32'd1;
  assign la     = part2_q ? a2 : ha_q;
  assign set_s  = la[12:6];
  assign tag_s  = la[31:13];
  assign span   = ha_q[12:6] != a2[12:6];
  assign off    = part2_q ? 6'd0 : ha_q[5:0];
  assign len1_w = 7'd64 - {1'b0, ha_q[5:0]};
  assign len1   = len1_w[2:0];
  assign at     = part2_q ? len1 : 3'd0;
  assign cnt    = part2_q ? (hs_q - len1) : (span ? len1 : hs_q);
  assign cmask  = byte_mask(cnt);
  assign sh_at  = {at[1:0], 3'b000};
  assign sh_off = {off[1:0], 3'b000};

  logic [31:0] ram_rd;
  assign buf64 = {ram_rd, w0_q};
  assign ext   = buf64[31:0] >> sh_off | 32'(buf64 >> sh_off);
  assign dsh   = (in_wdata_q >> sh_at) & cmask;
  assign d64   = {32'b0, dsh} << sh_off;
  assign m64   = {32'b0, cmask} << sh_off;

  logic [sawtc_pkg::TAG_W-1:0] tag_rd [WAYS];
  logic [WAYS-1:0] vrow;
  logic        found_hit, found_free;
  logic [WW-1:0] hway, fway, vmod, sel_way;
  logic [2:0]  victim;
  logic [3:0]  vr;

  assign vrow   = valid_q[set_s];
  assign victim = part2_q ? vs_q : vf_q;

  always_comb begin
    found_hit  = 1'b0;
    found_free = 1'b0;
    hway       = '0;
    fway       = '0;
    vr         = {1'b0, victim};
    for (int k = 0; k < 8; k++) begin
      if (vr >= 4'(WAYS)) begin
        vr = vr - 4'(WAYS);
      end
    end
    vmod = WW'(vr);
    for (int w = 0; w < WAYS; w++) begin
      if (vrow[w] && tag_rd[w] == tag_s && !found_hit) begin
        found_hit = 1'b1;
        hway      = WW'(w);
      end
      if (!vrow[w] && !found_free) begin
        found_free = 1'b1;
        fway       = WW'(w);
      end
    end
    sel_way = found_hit ? hway : (found_free ? fway : vmod);
  end

  for (genvar g = 0; g < WAYS; g++) begin : g_tag
    sawtc_ram #(
      .WIDTH(sawtc_pkg::TAG_W),
      .DEPTH(sawtc_pkg::NSETS)
    ) u_tag (
      .clk_i  (clk_i),
      .we_i   (cmd_i.fill_done && (way_q == WW'(g))),
      .addr_i (set_s),
      .wdata_i(tag_s),
      .wmask_i({sawtc_pkg::TAG_W{1'b1}}),
      .rdata_o(tag_rd[g])
    );
  end

  logic [LIW-1:0] line_idx;
  logic [3:0]     word;
  logic [31:0]    dwdata, dwmask;

  assign line_idx = LIW'(set_s) * LIW'(WAYS) + LIW'(way_q);

  always_comb begin
    case (cmd_i.dsel)
      sawtc_pkg::DSEL_FILL: begin
        word   = beat_q;
        dwdata = in_fword_q;
        dwmask = 32'hffff_ffff;
      end
      sawtc_pkg::DSEL_W0: begin
        word   = off[5:2];
        dwdata = d64[31:0];
        dwmask = m64[31:0];
      end
      default: begin
        word   = off[5:2] + 4'd1;
        dwdata = d64[63:32];
        dwmask = m64[63:32];
      end
    endcase
  end

  sawtc_ram #(
    .WIDTH(32),
    .DEPTH(DDEPTH)
  ) u_data (
    .clk_i  (clk_i),
    .we_i   (cmd_i.data_we),
    .addr_i (DAW'({line_idx, word})),
    .wdata_i(dwdata),
    .wmask_i(dwmask),
    .rdata_o(ram_rd)
  );

  logic [15:0] cost;
  logic [64:0] sum_c, sum_u;
  assign cost  = found_hit ? hit_cost_i : mem_cost_i;
  assign sum_c = {1'b0, cached_q} + 65'(cost);
  assign sum_u = {1'b0, uncached_q} + 65'(mem_cost_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_func_q  <= in_func_i;
      in_addr_q  <= in_addr_i;
      in_size_q  <= in_size_i;
      in_wdata_q <= in_wdata_i;
      in_vf_q    <= in_vf_i;
      in_vs_q    <= in_vs_i;
      in_fword_q <= in_fword_i;
    end
    if (cmd_i.cap_w0) begin
      w0_q <= ram_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ha_q          <= '0;
      hs_q          <= '0;
      vf_q          <= '0;
      vs_q          <= '0;
      part2_q       <= 1'b0;
      h1_q          <= 1'b0;
      h2_q          <= 1'b0;
      way_q         <= '0;
      fill_active_q <= 1'b0;
      beat_q        <= '0;
      assembled_q   <= '0;
      cached_q      <= '0;
      uncached_q    <= '0;
      for (int s = 0; s < sawtc_pkg::NSETS; s++) begin
        valid_q[s] <= '0;
      end
    end else begin
      if (cmd_i.start_access) begin
        ha_q        <= in_addr_q;
        hs_q        <= in_size_q;
        vf_q        <= in_vf_q;
        vs_q        <= in_vs_q;
        part2_q     <= 1'b0;
        h1_q        <= 1'b0;
        h2_q        <= 1'b0;
        assembled_q <= '0;
      end
      if (cmd_i.set_part2) begin
        part2_q <= 1'b1;
      end
      if (cmd_i.latch_way) begin
        way_q <= sel_way;
      end
      if (cmd_i.set_hit) begin
        if (part2_q) begin
          h2_q <= 1'b1;
        end else begin
          h1_q <= 1'b1;
        end
      end
      if (cmd_i.charge) begin
        cached_q   <= sum_c[64] ? '1 : sum_c[63:0];
        uncached_q <= sum_u[64] ? '1 : sum_u[63:0];
      end
      if (cmd_i.fill_start) begin
        fill_active_q <= 1'b1;
        beat_q        <= '0;
      end
      if (cmd_i.beat_inc) begin
        beat_q <= beat_q + 4'd1;
      end
      if (cmd_i.fill_done) begin
        fill_active_q         <= 1'b0;
        beat_q                <= '0;
        valid_q[set_s][way_q] <= 1'b1;
      end
      if (cmd_i.assemble) begin
        assembled_q <= assembled_q | ((ext & cmask) << sh_at);
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q     <= cmd_i.out_kind;
      out_rdata_q    <= (cmd_i.out_kind == sawtc_pkg::KIND_READ) ? assembled_q : 32'd0;
      out_h1_q       <= (cmd_i.out_kind != sawtc_pkg::KIND_ERROR) && h1_q;
      out_h2_q       <= (cmd_i.out_kind != sawtc_pkg::KIND_ERROR) && h2_q;
      out_cached_q   <= cached_q;
      out_uncached_q <= uncached_q;
      case (cmd_i.out_kind)
        sawtc_pkg::KIND_FILL: begin
          out_maddr_q <= {la[31:6], 6'b000000};
          out_mlen_q  <= 3'd0;
          out_mdata_q <= 32'd0;
        end
        sawtc_pkg::KIND_WRITE: begin
          out_maddr_q <= ha_q;
          out_mlen_q  <= hs_q;
          out_mdata_q <= in_wdata_q & byte_mask(hs_q);
        end
        default: begin
          out_maddr_q <= 32'd0;
          out_mlen_q  <= 3'd0;
          out_mdata_q <= 32'd0;
        end
      endcase
    end
  end

  assign stat_o.func        = in_func_q;
  assign stat_o.size_ok     = (in_size_q != 3'd0) && (in_size_q <= 3'd4);
  assign stat_o.fill_active = fill_active_q;
  assign stat_o.beat_last   = beat_q == 4'hf;
  assign stat_o.hit         = found_hit;
  assign stat_o.span        = span;
  assign stat_o.part2       = part2_q;
  assign stat_o.out_free    = out_free;

  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = out_kind_q;
  assign out_rdata_o      = out_rdata_q;
  assign out_hit_first_o  = out_h1_q;
  assign out_hit_second_o = out_h2_q;
  assign out_mem_addr_o   = out_maddr_q;
  assign out_mem_len_o    = out_mlen_q;
  assign out_mem_data_o   = out_mdata_q;
  assign out_cached_o     = out_cached_q;
  assign out_uncached_o   = out_uncached_q;

endmodule

// File: rtl/set_assoc_write_through_cache.sv
// Set-associative write-through cache, 128 sets of WAYS ways, 64-byte lines.
// Input stream: tuser carries func (read, write, fill word); tdata the access.
// Output stream: one result per read, write, fill request or error; tuser
// carries the kind. A read miss returns a fill request; the next 16
// fill-word transactions carry the line, and the last one resumes the read.
// Fill words before the last give no result. Steps from accept to result:
// decode, then per line part one tag RAM read and compare; a read hit adds
// two data RAM reads (the bytes may straddle two words), a write hit a
// masked write to each of the two words. A spanning access adds a second
// line part; an error goes straight from decode to the result.
// A new transaction is taken the cycle after the result is registered, while
// that result still waits on m_axis_tready; a stalled receiver holds the
// block in its emit state once a second result is ready.
// Reset clears all valid bits, the fill state and both cost counters at once.
// Config registers (APB, byte address 0 hit_cost, 4 memory_cost) must be
// written only while the block is idle; the block itself does not enforce it.
module set_assoc_write_through_cache #(
  parameter int unsigned WAYS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // addr[31:0] size[34:32] wdata[66:35] victim_first[69:67]
  // victim_second[72:70] fill_word[104:73]
  input  logic [111:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rdata[31:0] hit_first[32] hit_second[33] mem_addr[65:34] mem_len[68:66]
  // mem_data[100:69] cached_cost[164:101] uncached_cost[228:165]
  output logic [231:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic REG_HIT_COST = 1'b0;
  localparam logic REG_MEM_COST = 1'b1;

  logic [15:0] hit_cost_q, mem_cost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cost_q <= 16'd1;
      mem_cost_q <= 16'd10;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_HIT_COST: hit_cost_q <= pwdata[15:0];
        default:      mem_cost_q <= pwdata[15:0];
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = {16'd0, (paddr[2] == REG_MEM_COST) ? mem_cost_q : hit_cost_q};

  sawtc_pkg::cmd_t  cmd;
  sawtc_pkg::stat_t stat;

  sawtc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  logic [31:0] rdata, mem_addr, mem_data;
  logic        hit_first, hit_second;
  logic [2:0]  mem_len;
  logic [63:0] cached, uncached;

  sawtc_dp #(
    .WAYS(WAYS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_func_i       (s_axis_tuser),
    .in_addr_i       (s_axis_tdata[31:0]),
    .in_size_i       (s_axis_tdata[34:32]),
    .in_wdata_i      (s_axis_tdata[66:35]),
    .in_vf_i         (s_axis_tdata[69:67]),
    .in_vs_i         (s_axis_tdata[72:70]),
    .in_fword_i      (s_axis_tdata[104:73]),
    .hit_cost_i      (hit_cost_q),
    .mem_cost_i      (mem_cost_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_kind_o      (m_axis_tuser),
    .out_rdata_o     (rdata),
    .out_hit_first_o (hit_first),
    .out_hit_second_o(hit_second),
    .out_mem_addr_o  (mem_addr),
    .out_mem_len_o   (mem_len),
    .out_mem_data_o  (mem_data),
    .out_cached_o    (cached),
    .out_uncached_o  (uncached)
  );

  assign m_axis_tdata = {3'b000, uncached, cached, mem_data, mem_len, mem_addr,
                         hit_second, hit_first, rdata};

  a_accept_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again right after a transaction");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over a pending result");

  a_beat_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.beat_last |-> stat.fill_active)
    else $error("fill beat count outside a fill");

endmodule
